// ===== sv/assert_macros.svh =====
// assertion helper macros for the display control program executor checker
// no dependencies; take in with a plain include before the assertions

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dcpe_pkg.sv =====
// shared types, codes and constants of the display control program executor
// no dependencies; imported by the executor datapath, top level and checker
`default_nettype none

package dcpe_pkg;

  // field widths
  localparam int ADDR_W         = 22;
  localparam int STEP_W         = 12;
  localparam int DATA_W         = 24;
  localparam int COLOUR_ENTRIES = 256;
  localparam int IDX_W          = $clog2(COLOUR_ENTRIES);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 22;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERLACE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LINE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_BASE = 2'd2;

  localparam logic [ADDR_W-1:0] FIELD_BASE_RESET = 22'd1024;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FIELD = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  // instruction opcodes below the write range
  localparam logic [3:0] OP_STOP        = 4'd0;
  localparam logic [3:0] OP_NOP         = 4'd1;
  localparam logic [3:0] OP_LOAD_PTR    = 4'd2;
  localparam logic [3:0] OP_LOAD_PTR_ST = 4'd3;
  localparam logic [3:0] OP_LOAD_ADDR   = 4'd4;
  localparam logic [3:0] OP_LOAD_VID_ST = 4'd5;
  localparam logic [3:0] OP_INTERRUPT   = 4'd6;
  localparam logic [3:0] OP_PARAMS      = 4'd7;

  // write kinds
  localparam logic [1:0] WK_NONE   = 2'd0;
  localparam logic [1:0] WK_COLOUR = 2'd1;
  localparam logic [1:0] WK_CTRL   = 2'd2;

  // address and data masks, control register decode
  localparam logic [ADDR_W-1:0] LINE_MASK  = 22'h3F_FFFC;
  localparam logic [ADDR_W-1:0] FETCH_STEP = 22'd4;
  localparam logic [31:0]       CTRL_BOUND = 32'hC000_0000;
  localparam logic [7:0]        REG_OFFSET = 8'h80;

  // run lengths
  localparam logic [STEP_W-1:0] MAX_FIELD_STEPS = 12'd2000;
  localparam logic [STEP_W-1:0] SHORT_LINE_LEN  = 12'd8;
  localparam logic [STEP_W-1:0] LONG_LINE_LEN   = 12'd16;

  // colour bank select register within the control file
  localparam int               BANK_REG_INDEX = 67;
  localparam int               CTRL_BASE      = 64;
  localparam logic [5:0]       BANK_SLOT      = 6'((BANK_REG_INDEX - CTRL_BASE) % 64);

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instruction_word;
    logic        odd_field;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic              done_res;
    logic              interrupt_pulse;
    logic              reload_params;
    logic              param_bit4;
    logic [1:0]        param_bits3_2;
    logic [1:0]        param_bits1_0;
    logic [ADDR_W-1:0] display_pointer;
    logic [ADDR_W-1:0] video_start;
    logic [1:0]        write_kind;
    logic [IDX_W-1:0]  write_index;
    logic [DATA_W-1:0] write_data;
  } out_item_t;

  typedef struct packed {
    logic              interlace_mode;
    logic              long_line_program;
    logic [ADDR_W-1:0] field_program_base;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] field_address;
    logic [ADDR_W-1:0] line_pointer;
    logic [ADDR_W-1:0] video_start;
    logic [STEP_W-1:0] step_counter;
    logic              stopped;
    logic              line_run;
    logic [1:0]        bank;
  } state_t;

endpackage

`default_nettype wire

// ===== sv/dcpe_exec.sv =====
// instruction decode and execute: next program state and result for one request
// purely combinational; depends on dcpe_pkg
`default_nettype none

module dcpe_exec (
  input  dcpe_pkg::in_item_t  item,
  input  dcpe_pkg::state_t    st,
  input  dcpe_pkg::cfg_t      cfg,
  output dcpe_pkg::state_t    st_nxt,
  output dcpe_pkg::out_item_t res
);
  import dcpe_pkg::*;

  logic              exec;
  logic              is_line;
  logic              stop;
  logic              jumped;
  logic [3:0]        op;
  logic [7:0]        top_byte;
  logic [6:0]        reg_num;
  logic [STEP_W-1:0] step_inc;
  logic [STEP_W-1:0] limit;
  logic [31:0]       w;
  state_t            s;

  assign w        = item.instruction_word;
  assign op       = w[31:28];
  assign top_byte = w[31:24] - REG_OFFSET;
  assign reg_num  = top_byte[6:0];
  assign is_line  = (item.command == CMD_LINE);

  always_comb begin
    s        = st;
    exec     = 1'b0;
    stop     = 1'b0;
    jumped   = 1'b0;
    step_inc = '0;
    limit    = '0;
    res      = '0;

    // command handling: start, run entry and run gating
    unique case (item.command)
      CMD_START: begin
        s.field_address = (cfg.interlace_mode && !item.odd_field)
                          ? cfg.field_program_base + FETCH_STEP
                          : cfg.field_program_base;
        s.step_counter  = '0;
        s.stopped       = 1'b0;
        s.line_run      = 1'b0;
      end
      CMD_FIELD: exec = !st.stopped && !st.line_run;
      CMD_LINE: begin
        if (st.stopped) begin
          s.stopped      = 1'b0;
          s.line_run     = 1'b1;
          s.step_counter = '0;
          exec           = 1'b1;
        end else begin
          exec = st.line_run;
        end
      end
      default: ;
    endcase

    if (exec) begin
      // opcode decode
      unique case (op)
        OP_STOP: stop = 1'b1;
        OP_NOP: ;
        OP_LOAD_PTR: begin
          s.line_pointer = w[ADDR_W-1:0] & LINE_MASK;
          jumped         = is_line;
        end
        OP_LOAD_PTR_ST: begin
          s.line_pointer = w[ADDR_W-1:0] & LINE_MASK;
          stop           = 1'b1;
        end
        OP_LOAD_ADDR: begin
          if (is_line) begin
            s.video_start = w[ADDR_W-1:0];
          end else begin
            s.field_address = w[ADDR_W-1:0];
            jumped          = 1'b1;
          end
        end
        OP_LOAD_VID_ST: begin
          s.video_start = w[ADDR_W-1:0];
          stop          = 1'b1;
        end
        OP_INTERRUPT: res.interrupt_pulse = 1'b1;
        OP_PARAMS: begin
          res.reload_params = 1'b1;
          res.param_bit4    = w[4];
          res.param_bits3_2 = w[3:2];
          res.param_bits1_0 = w[1:0];
        end
        default: begin
          // colour entry or control register write
          res.write_data = w[DATA_W-1:0];
          if (w < CTRL_BOUND) begin
            res.write_kind  = WK_COLOUR;
            res.write_index = {s.bank, reg_num[5:0]};
          end else begin
            res.write_kind  = WK_CTRL;
            res.write_index = {1'b0, reg_num};
            if (reg_num[5:0] == BANK_SLOT) begin
              s.bank = w[1:0];
            end
          end
        end
      endcase

      // advance fetch address and step count, end of run
      if (stop) begin
        s.stopped = 1'b1;
      end else begin
        if (!jumped) begin
          if (is_line) begin
            s.line_pointer = s.line_pointer + FETCH_STEP;
          end else begin
            s.field_address = s.field_address + FETCH_STEP;
          end
        end
        step_inc       = s.step_counter + 12'd1;
        s.step_counter = step_inc;
        limit          = is_line ? (cfg.long_line_program ? LONG_LINE_LEN : SHORT_LINE_LEN)
                                 : MAX_FIELD_STEPS;
        if (step_inc >= limit) begin
          s.stopped = 1'b1;
        end
      end
    end

    // status part of the result
    res.next_address    = s.line_run ? s.line_pointer : s.field_address;
    res.done_res        = s.stopped;
    res.display_pointer = s.line_pointer;
    res.video_start     = s.video_start;
    st_nxt              = s;
  end

endmodule

`default_nettype wire

// ===== sv/display_control_program_executor_unit.sv =====
// display control program executor: one request per cycle unless the result side stalls
// an input register feeds the decode logic, the result lands in an output register
// sustained one request per cycle without stalls, set by the registered state update loop
// synchronous active-low reset: stopped, field run, pointers zero, bank 0, base 1024
// depends on dcpe_pkg and dcpe_exec
`default_nettype none

module display_control_program_executor_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  dcpe_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output dcpe_pkg::out_item_t               out_data,
  input  wire                               cfg_we,
  input  wire  [dcpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dcpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dcpe_pkg::*;

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  state_t    st_r;
  state_t    st_nxt;
  cfg_t      cfg_r;
  out_item_t res;
  logic      advance;
  logic      in_accept;

  // handshake: input stage moves on when the output register is free or being taken
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // decode and execute
  dcpe_exec u_exec (
    .item   (in_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interlace_mode     <= 1'b0;
      cfg_r.long_line_program  <= 1'b0;
      cfg_r.field_program_base <= FIELD_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERLACE:  cfg_r.interlace_mode     <= cfg_wdata[0];
        REG_LONG_LINE:  cfg_r.long_line_program  <= cfg_wdata[0];
        REG_FIELD_BASE: cfg_r.field_program_base <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  // program state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.field_address <= '0;
      st_r.line_pointer  <= '0;
      st_r.video_start   <= '0;
      st_r.step_counter  <= '0;
      st_r.stopped       <= 1'b1;
      st_r.line_run      <= 1'b0;
      st_r.bank          <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dcpe_checker.sv =====
// port-level checks on the executor's result channel, bound to the top level
// depends on dcpe_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module dcpe_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input dcpe_pkg::out_item_t out_data
);
  import dcpe_pkg::*;

  logic kind_legal;
  logic write_empty;
  logic ctrl_in_range;
  logic one_action;

  // result field predicates
  assign kind_legal    = out_data.write_kind == WK_NONE || out_data.write_kind == WK_COLOUR ||
                         out_data.write_kind == WK_CTRL;
  assign write_empty   = out_data.write_index == '0 && out_data.write_data == '0;
  assign ctrl_in_range = out_data.write_index[7:6] == 2'b01;
  assign one_action    = $countones({out_data.interrupt_pulse, out_data.reload_params,
                                     out_data.write_kind != WK_NONE}) <= 1;

  // a stalled result holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // only the defined write kinds appear
  `CHK_IMPLY(a_kind_legal, clk, rst_n, out_valid, kind_legal, "illegal write kind")

  // no write means empty write fields
  `CHK_IMPLY(a_no_write_zero, clk, rst_n, out_valid && out_data.write_kind == WK_NONE, write_empty, "write fields set without a write")

  // control register writes land in the upper register half
  `CHK_IMPLY(a_ctrl_index, clk, rst_n, out_valid && out_data.write_kind == WK_CTRL, ctrl_in_range, "control register index out of range")

  // one opcode per request: pulses and writes exclude each other
  `CHK_ALWAYS(a_one_action, clk, rst_n, !out_valid || one_action, "more than one action in a result")

endmodule

bind display_control_program_executor_unit dcpe_checker u_dcpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/display_control_program_executor_unit_tb.sv =====
// self-checking bench for the display control program executor unit
// needs dcpe_pkg and the executor rtl; drives requests, mirrors the executor, checks each result
`default_nettype none

module display_control_program_executor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcpe_pkg::*;

  localparam int          CLK_PERIOD  = 4;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          PHASE_ITEMS = 165;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  // one row of the directed table: pinned rows carry a hand-written result
  typedef struct packed {
    logic      pinned;
    in_item_t  req;
    out_item_t res;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // mirrored executor state and registers
  cfg_t              prog_cfg         = '{1'b0, 1'b0, FIELD_BASE_RESET};
  logic [ADDR_W-1:0] prog_field_addr  = '0;
  logic [ADDR_W-1:0] prog_line_ptr    = '0;
  logic [ADDR_W-1:0] prog_video_start = '0;
  logic [STEP_W-1:0] prog_steps       = '0;
  logic              prog_stopped     = 1'b1;
  logic              prog_line_run    = 1'b0;
  logic [DATA_W-1:0] prog_ctrl [64]   = '{default: '0};
  logic [DATA_W-1:0] prog_colour [COLOUR_ENTRIES] = '{default: '0};

  out_item_t   due_results [$];
  logic        pin_on;
  out_item_t   pin_res;
  logic        feed_steady = 1'b0;
  logic        sink_steady = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned faults = 0;
  int unsigned cycle_count = 0;

  plan_row_t directed_plan [27] = '{
    '{1'b1, '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1}, '{done_res: 1'b1, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h6000_0000, 1'b0}, '{done_res: 1'b1, default: 0}},
    '{1'b1, '{CMD_START, 32'hFFFF_FFFF, 1'b0}, '{next_address: 22'h400, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h7000_001F, 1'b1}, '{next_address: 22'h404, reload_params: 1'b1,
      param_bit4: 1'b1, param_bits3_2: 2'd3, param_bits1_0: 2'd3, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h6000_0000, 1'b0}, '{next_address: 22'h408, interrupt_pulse: 1'b1,
      default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h2FFF_FFFF, 1'b0}, '{next_address: 22'h40C,
      display_pointer: 22'h3F_FFFC, default: 0}},
    '{1'b1, '{CMD_LINE, 32'h1000_0000, 1'b1}, '{next_address: 22'h40C,
      display_pointer: 22'h3F_FFFC, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h4000_0000, 1'b0}, '{display_pointer: 22'h3F_FFFC, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'hBF00_0000, 1'b0}, '{next_address: 22'h4,
      display_pointer: 22'h3F_FFFC, write_kind: WK_COLOUR, write_index: 8'd63, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h80FF_FFFF, 1'b1}, '{next_address: 22'h8,
      display_pointer: 22'h3F_FFFC, write_kind: WK_COLOUR, write_data: 24'hFF_FFFF,
      default: 0}},
    '{1'b1, '{CMD_FIELD, 32'hC300_0003, 1'b0}, '{next_address: 22'hC,
      display_pointer: 22'h3F_FFFC, write_kind: WK_CTRL, write_index: 8'd67,
      write_data: 24'd3, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'hBFAB_CDEF, 1'b0}, '{next_address: 22'h10,
      display_pointer: 22'h3F_FFFC, write_kind: WK_COLOUR, write_index: 8'd255,
      write_data: 24'hAB_CDEF, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'hFFFF_FFFF, 1'b1}, '{next_address: 22'h14,
      display_pointer: 22'h3F_FFFC, write_kind: WK_CTRL, write_index: 8'd127,
      write_data: 24'hFF_FFFF, default: 0}},
    '{1'b1, '{CMD_FIELD, 32'h53FF_FFFF, 1'b0}, '{next_address: 22'h14, done_res: 1'b1,
      display_pointer: 22'h3F_FFFC, video_start: 22'h3F_FFFF, default: 0}},
    '{1'b1, '{CMD_LINE, 32'h2000_0101, 1'b1}, '{next_address: 22'h100,
      display_pointer: 22'h100, video_start: 22'h3F_FFFF, default: 0}},
    '{1'b1, '{CMD_LINE, 32'h4012_3456, 1'b0}, '{next_address: 22'h104,
      display_pointer: 22'h104, video_start: 22'h12_3456, default: 0}},
    '{1'b0, '{CMD_FIELD, 32'h7000_0000, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h0000_0000, 1'b1}, '0},
    '{1'b0, '{CMD_LINE, 32'h3FFF_FFFF, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b1}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b1}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b1}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b0}, '0},
    '{1'b0, '{CMD_LINE, 32'h1000_0000, 1'b1}, '0}
  };

  display_control_program_executor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // executes one request on the mirrored state and returns the result it should give
  function automatic out_item_t step_program(in_item_t req);
    out_item_t         res;
    logic [31:0]       w;
    logic [3:0]        op;
    logic [6:0]        reg_no;
    logic [STEP_W-1:0] limit;
    logic              exec;
    logic              stop;
    logic              jumped;
    logic              is_line;
    res     = '0;
    w       = req.instruction_word;
    op      = w[31:28];
    exec    = 1'b0;
    stop    = 1'b0;
    jumped  = 1'b0;
    is_line = (req.command == CMD_LINE);

    // command decode: start, run gating, line run entry
    case (req.command)
      CMD_START: begin
        prog_field_addr = prog_cfg.field_program_base;
        if (prog_cfg.interlace_mode && !req.odd_field) begin
          prog_field_addr = prog_field_addr + FETCH_STEP;
        end
        prog_steps    = '0;
        prog_stopped  = 1'b0;
        prog_line_run = 1'b0;
      end
      CMD_FIELD: exec = !prog_stopped && !prog_line_run;
      CMD_LINE: begin
        if (prog_stopped) begin
          prog_stopped  = 1'b0;
          prog_line_run = 1'b1;
          prog_steps    = '0;
          exec          = 1'b1;
        end else begin
          exec = prog_line_run;
        end
      end
      default: ;
    endcase

    if (exec) begin
      // opcode execution
      case (op)
        OP_STOP: stop = 1'b1;
        OP_NOP: ;
        OP_LOAD_PTR: begin
          prog_line_ptr = w[ADDR_W-1:0] & LINE_MASK;
          jumped        = is_line;
        end
        OP_LOAD_PTR_ST: begin
          prog_line_ptr = w[ADDR_W-1:0] & LINE_MASK;
          stop          = 1'b1;
        end
        OP_LOAD_ADDR: begin
          if (is_line) begin
            prog_video_start = w[ADDR_W-1:0];
          end else begin
            prog_field_addr = w[ADDR_W-1:0];
            jumped          = 1'b1;
          end
        end
        OP_LOAD_VID_ST: begin
          prog_video_start = w[ADDR_W-1:0];
          stop             = 1'b1;
        end
        OP_INTERRUPT: res.interrupt_pulse = 1'b1;
        OP_PARAMS: begin
          res.reload_params = 1'b1;
          res.param_bit4    = w[4];
          res.param_bits3_2 = w[3:2];
          res.param_bits1_0 = w[1:0];
        end
        default: begin
          // colour entry below the control boundary, control register above it
          reg_no         = 7'(w[31:24] - REG_OFFSET);
          res.write_data = w[DATA_W-1:0];
          if (w < CTRL_BOUND) begin
            res.write_kind                = WK_COLOUR;
            res.write_index               = {prog_ctrl[BANK_SLOT][1:0], reg_no[5:0]};
            prog_colour[res.write_index]  = w[DATA_W-1:0];
          end else begin
            res.write_kind         = WK_CTRL;
            res.write_index        = {1'b0, reg_no};
            prog_ctrl[reg_no[5:0]] = w[DATA_W-1:0];
          end
        end
      endcase

      // fetch advance and run length
      if (stop) begin
        prog_stopped = 1'b1;
      end else begin
        if (!jumped) begin
          if (is_line) begin
            prog_line_ptr = prog_line_ptr + FETCH_STEP;
          end else begin
            prog_field_addr = prog_field_addr + FETCH_STEP;
          end
        end
        prog_steps = prog_steps + 12'd1;
        if (is_line) begin
          limit = prog_cfg.long_line_program ? LONG_LINE_LEN : SHORT_LINE_LEN;
        end else begin
          limit = MAX_FIELD_STEPS;
        end
        if (prog_steps >= limit) begin
          prog_stopped = 1'b1;
        end
      end
    end

    res.next_address    = prog_line_run ? prog_line_ptr : prog_field_addr;
    res.done_res        = prog_stopped;
    res.display_pointer = prog_line_ptr;
    res.video_start     = prog_video_start;
    return res;
  endfunction

  // instruction word with a random opcode; stop opcodes kept rare so runs go deep
  function automatic logic [31:0] random_word(logic may_stop);
    logic [3:0]  op;
    logic [31:0] w;
    op = 4'($urandom_range(0, 15));
    if (op inside {OP_STOP, OP_LOAD_PTR_ST, OP_LOAD_VID_ST} &&
        (!may_stop || $urandom_range(0, 3) != 0)) begin
      do op = 4'($urandom_range(0, 15));
      while (op inside {OP_STOP, OP_LOAD_PTR_ST, OP_LOAD_VID_ST});
    end
    w = {op, 28'($urandom)};
    // steer some control writes at the colour bank register
    if (w >= CTRL_BOUND && $urandom_range(0, 7) == 0) begin
      w[31:24] = REG_OFFSET + 8'(BANK_REG_INDEX);
    end
    return w;
  endfunction

  // present one request after a random gap and hold it until taken
  task automatic send_request(in_item_t req);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // stop feeding and wait for every outstanding result
  task automatic drain();
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // write all three registers; 1-bit registers get random upper bits
  task automatic program_registers(logic interlace, logic long_line, logic [ADDR_W-1:0] base);
    cfg_we    = 1'b1;
    cfg_index = REG_INTERLACE;
    cfg_wdata = {21'($urandom), interlace};
    @(negedge clk);
    cfg_index = REG_LONG_LINE;
    cfg_wdata = {21'($urandom), long_line};
    @(negedge clk);
    cfg_index = REG_FIELD_BASE;
    cfg_wdata = base;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // accepted requests, register writes and results, all seen at the rising edge
  always @(posedge clk) begin
    out_item_t forecast;
    out_item_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTERLACE:  prog_cfg.interlace_mode     = cfg_wdata[0];
          REG_LONG_LINE:  prog_cfg.long_line_program  = cfg_wdata[0];
          REG_FIELD_BASE: prog_cfg.field_program_base = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        forecast = step_program(in_data);
        if (pin_on) forecast = pin_res;
        due_results = {due_results, forecast};
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          faults++;
          if (faults <= 10) $display("result with no request outstanding: %p", got);
        end else begin
          forecast = due_results.pop_front();
          if (got !== forecast) begin
            faults++;
            if (faults <= 10) begin
              $display("result mismatch\n  expected %p\n  actual   %p", forecast, got);
            end
          end
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall before each result, with steady stretches
  initial begin
    int hold;
    int unsigned taken;
    taken     = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 64 == 0) sink_steady = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  // stimulus: directed table, then random phases
  initial begin
    int kind;
    int unsigned phase_end;
    logic [ADDR_W-1:0] base;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pin_on    = 1'b0;
    pin_res   = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed rows with the reset register values
    foreach (directed_plan[i]) begin
      pin_on  = directed_plan[i].pinned;
      pin_res = directed_plan[i].res;
      send_request(directed_plan[i].req);
    end
    pin_on = 1'b0;

    // random phases over several register settings, extremes first
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       base = '0;
        1:       base = '1;
        2:       base = LINE_MASK;
        default: base = 22'($urandom);
      endcase
      program_registers(1'(phase % 2), 1'((phase / 2) % 2), base);
      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        feed_steady = ($urandom_range(0, 4) == 0);
        kind        = $urandom_range(0, 9);
        if (kind < 5) begin
          // field program: start then a burst of field words
          send_request('{CMD_START, $urandom, 1'($urandom)});
          repeat ($urandom_range(1, 40)) begin
            send_request('{CMD_FIELD, random_word(1'b1), 1'($urandom)});
          end
        end else if (kind < 9) begin
          // line program words
          repeat ($urandom_range(1, 20)) begin
            send_request('{CMD_LINE, random_word(1'b1), 1'($urandom)});
          end
        end else begin
          // noise: any command, any word
          repeat ($urandom_range(1, 6)) begin
            send_request('{2'($urandom), $urandom, 1'($urandom)});
          end
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    faults += due_results.size();
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/dcpe_pkg.sv
sv/dcpe_exec.sv
sv/display_control_program_executor_unit.sv
sv/dcpe_checker.sv
verif/display_control_program_executor_unit_tb.sv
